FILE: rtl/core/scg_pkg.sv
`default_nettype none

package scg_pkg;

  // Field widths fixed by the item formats.
  localparam int unsigned OP_W       = 2;
  localparam int unsigned JOINT_W    = 5;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned DEBOUNCE_W = 8;
  localparam int unsigned TICKS_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned QUOT_W     = 16;
  localparam int unsigned PROD_W     = 32;

  // Default joint count.
  localparam int unsigned NUM_JOINTS_DEF = 32;

  // Register reset values.
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 8'd3;
  localparam logic [TICKS_W-1:0]    WARMUP_RST   = 16'd500;
  localparam logic [TICKS_W-1:0]    RAMP_RST     = 16'd500;
  localparam logic [POS_W-1:0]      CENTER_RST   = 16'd0;

  // Request kinds.
  typedef enum logic [OP_W-1:0] {
    OP_TICK = 2'd0,
    OP_POLL = 2'd1,
    OP_MARK = 2'd2,
    OP_CMD  = 2'd3
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_WARMUP   = 2'd1,
    CFG_RAMP     = 2'd2,
    CFG_CENTER   = 2'd3
  } cfg_reg_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ELAPSED,
    S_GATE,
    S_PRODUCT,
    S_DIV_LOAD,
    S_DIVIDE,
    S_BLEND,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic decode;
    logic elapsed;
    logic gate;
    logic product;
    logic div_start;
    logic blend;
    logic load_out;
  } scg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic cmd_early;
    logic warm_hold;
    logic in_ramp;
    logic div_done;
  } scg_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/scg_ram.sv
`default_nettype none

module scg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/scg_div.sv
`default_nettype none

module scg_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [scg_pkg::PROD_W-1:0]    dividend,
  input  wire logic [scg_pkg::QUOT_W-1:0]    divisor,
  output logic      [scg_pkg::QUOT_W-1:0]    quotient,
  output logic                               done
);

  import scg_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUOT_W + 1);

  logic [QUOT_W-1:0] remainder;
  logic [QUOT_W-1:0] quo;
  logic [CNT_W-1:0]  count;
  logic [QUOT_W:0]   shifted;
  logic [QUOT_W:0]   trial;
  logic              fits;

  // One restoring step: shift in the next dividend bit and try the subtract.
  // The upper half of the dividend is always below the divisor, so the
  // quotient fits in QUOT_W bits.
  always_comb begin
    shifted = {remainder, quo[QUOT_W-1]};
    trial   = shifted - {1'b0, divisor};
    fits    = (shifted >= {1'b0, divisor});
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CNT_W'(QUOT_W);
    end else if (count != '0) begin
      count <= count - CNT_W'(1);
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= dividend[PROD_W-1:QUOT_W];
      quo       <= dividend[QUOT_W-1:0];
    end else if (count != '0) begin
      remainder <= fits ? trial[QUOT_W-1:0] : shifted[QUOT_W-1:0];
      quo       <= {quo[QUOT_W-2:0], fits};
    end
  end

  assign quotient = quo;
  assign done     = (count == '0);

endmodule

`default_nettype wire

FILE: rtl/core/scg_datapath.sv
`default_nettype none

module scg_datapath #(
  parameter int unsigned NUM_JOINTS = scg_pkg::NUM_JOINTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire scg_pkg::scg_cmd_t                 cmd,
  output scg_pkg::scg_status_t                   status,
  input  wire logic [scg_pkg::OP_W-1:0]          opcode,
  input  wire logic [scg_pkg::JOINT_W-1:0]       joint_index,
  input  wire logic                              read_ok,
  input  wire logic signed [scg_pkg::POS_W-1:0]  position_in,
  input  wire logic                              cfg_write,
  input  wire logic [scg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [scg_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                   accepted,
  output logic signed [scg_pkg::POS_W-1:0]       position_out,
  output logic      [scg_pkg::JOINT_W-1:0]       polled_joint,
  output logic                                   link_up,
  output logic                                   reenable_request
);

  import scg_pkg::*;

  localparam int unsigned JW    = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int unsigned REC_W = TIME_W + POS_W;

  // Configuration registers.
  logic [DEBOUNCE_W-1:0] debounce_count;
  logic [TICKS_W-1:0]    warmup_ticks;
  logic [TICKS_W-1:0]    ramp_ticks;
  logic [POS_W-1:0]      center_position;

  // Captured request.
  op_t                op;
  logic [JOINT_W-1:0] joint;
  logic               ok;
  logic [POS_W-1:0]   pos;

  // Per-block and per-joint state.
  logic [TIME_W-1:0]     now_ticks;
  logic [JW-1:0]         poll_index;
  logic                  link_flag        [NUM_JOINTS];
  logic [DEBOUNCE_W-1:0] mismatch_counter [NUM_JOINTS];
  logic                  warm_valid       [NUM_JOINTS];

  // Command path work registers.
  logic [POS_W-1:0]  start_pos;
  logic [TIME_W-1:0] elapsed;
  logic [POS_W:0]    diff;
  logic [TIME_W-1:0] remain;
  logic [PROD_W-1:0] product;
  logic              diff_neg;

  // Result under construction.
  logic               res_accepted;
  logic [POS_W-1:0]   res_position;
  logic [JOINT_W-1:0] res_polled;
  logic               res_link;
  logic               res_reenable;

  // Combinational helpers.
  logic                  joint_ok;
  logic [JW-1:0]         jsel;
  logic                  connected;
  logic                  marked;
  logic                  poll_flag;
  logic [DEBOUNCE_W-1:0] count_inc;
  logic                  flip;
  logic                  new_link;
  logic [JW-1:0]         poll_next;
  logic [POS_W:0]        diff_abs;
  logic [REC_W-1:0]      rec_wdata;
  logic [REC_W-1:0]      rec_rdata;
  logic [QUOT_W-1:0]     quotient;
  logic                  div_done;
  logic [POS_W:0]        quot_signed;
  logic [POS_W:0]        blend_sum;

  // Joint lookup and poll debounce decision.
  always_comb begin
    joint_ok  = ({1'b0, joint} < (JOINT_W + 1)'(NUM_JOINTS));
    jsel      = joint[JW-1:0];
    connected = joint_ok ? link_flag[jsel] : 1'b1;
    marked    = joint_ok && warm_valid[jsel];
    poll_flag = link_flag[poll_index];
    count_inc = mismatch_counter[poll_index] + DEBOUNCE_W'(1);
    flip      = (ok != poll_flag) && !(count_inc < debounce_count);
    new_link  = flip ? ok : poll_flag;
    poll_next = (poll_index == JW'(NUM_JOINTS - 1)) ? '0 : poll_index + JW'(1);
    diff_abs  = diff[POS_W] ? (~diff + (POS_W + 1)'(1)) : diff;
    rec_wdata = {now_ticks, (ok ? pos : center_position)};
    quot_signed = diff_neg ? ((POS_W + 1)'(0) - {1'b0, quotient})
                           : {1'b0, quotient};
    blend_sum = {start_pos[POS_W-1], start_pos} + quot_signed;
  end

  // Status toward the controller.
  always_comb begin
    status.op        = op;
    status.cmd_early = !connected || !marked;
    status.warm_hold = (elapsed < {{(TIME_W - TICKS_W){1'b0}}, warmup_ticks});
    status.in_ramp   = (remain < {{(TIME_W - TICKS_W){1'b0}}, ramp_ticks});
    status.div_done  = div_done;
  end

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_count  <= DEBOUNCE_RST;
      warmup_ticks    <= WARMUP_RST;
      ramp_ticks      <= RAMP_RST;
      center_position <= CENTER_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DEBOUNCE: debounce_count  <= cfg_data[DEBOUNCE_W-1:0];
        CFG_WARMUP:   warmup_ticks    <= cfg_data[TICKS_W-1:0];
        CFG_RAMP:     ramp_ticks      <= cfg_data[TICKS_W-1:0];
        CFG_CENTER:   center_position <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clock, poll and torque-enable state updated when a request is decoded.
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ticks  <= '0;
      poll_index <= '0;
      for (int i = 0; i < NUM_JOINTS; i++) begin
        link_flag[i]        <= 1'b1;
        mismatch_counter[i] <= '0;
        warm_valid[i]       <= 1'b0;
      end
    end else if (cmd.decode) begin
      case (op)
        OP_TICK: now_ticks <= now_ticks + TIME_W'(1);
        OP_POLL: begin
          poll_index <= poll_next;
          link_flag[poll_index] <= new_link;
          if (ok == poll_flag || flip) begin
            mismatch_counter[poll_index] <= '0;
          end else begin
            mismatch_counter[poll_index] <= count_inc;
          end
        end
        OP_MARK: begin
          if (joint_ok) begin
            warm_valid[jsel] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Request capture and command arithmetic.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op    <= op_t'(opcode);
      joint <= joint_index;
      ok    <= read_ok;
      pos   <= position_in;
    end
    if (cmd.elapsed) begin
      start_pos <= rec_rdata[POS_W-1:0];
      elapsed   <= now_ticks - rec_rdata[REC_W-1:POS_W];
      diff      <= {pos[POS_W-1], pos} - {rec_rdata[POS_W-1], rec_rdata[POS_W-1:0]};
    end
    if (cmd.gate) begin
      remain <= elapsed - {{(TIME_W - TICKS_W){1'b0}}, warmup_ticks};
    end
    if (cmd.product) begin
      product  <= PROD_W'(diff_abs[POS_W-1:0]) * PROD_W'(remain[POS_W-1:0]);
      diff_neg <= diff[POS_W];
    end
  end

  // Result fields.
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      res_accepted <= 1'b0;
      res_position <= '0;
      res_polled   <= '0;
      res_link     <= 1'b0;
      res_reenable <= 1'b0;
      case (op)
        OP_POLL: begin
          res_polled   <= JOINT_W'(poll_index);
          res_link     <= new_link;
          res_reenable <= flip && ok;
        end
        OP_CMD: begin
          if (connected) begin
            res_accepted <= 1'b1;
            res_position <= pos;
          end
        end
        default: ;
      endcase
    end else if (cmd.gate && status.warm_hold) begin
      res_accepted <= 1'b0;
      res_position <= '0;
    end else if (cmd.blend) begin
      res_position <= blend_sum[POS_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      accepted         <= res_accepted;
      position_out     <= res_position;
      polled_joint     <= res_polled;
      link_up          <= res_link;
      reenable_request <= res_reenable;
    end
  end

  // Torque-enable record: start time and start position per joint.
  scg_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_JOINTS)
  ) u_record (
    .clk     (clk),
    .wr_en   (cmd.decode && (op == OP_MARK) && joint_ok),
    .wr_addr (jsel),
    .wr_data (rec_wdata),
    .rd_addr (jsel),
    .rd_data (rec_rdata)
  );

  // Serial divider for the ramp blend.
  scg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (product),
    .divisor  (ramp_ticks),
    .quotient (quotient),
    .done     (div_done)
  );

endmodule

`default_nettype wire

FILE: rtl/core/scg_ctrl.sv
`default_nettype none

module scg_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  input  wire scg_pkg::scg_status_t   status,
  output scg_pkg::scg_cmd_t           cmd
);

  import scg_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (status.op == OP_CMD && !status.cmd_early) begin
          state_next = S_ELAPSED;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_ELAPSED: begin
        cmd.elapsed = 1'b1;
        state_next  = S_GATE;
      end
      S_GATE: begin
        cmd.gate   = 1'b1;
        state_next = status.warm_hold ? S_FINISH : S_PRODUCT;
      end
      S_PRODUCT: begin
        cmd.product = 1'b1;
        state_next  = status.in_ramp ? S_DIV_LOAD : S_FINISH;
      end
      S_DIV_LOAD: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVIDE;
      end
      S_DIVIDE: begin
        if (status.div_done) begin
          state_next = S_BLEND;
        end
      end
      S_BLEND: begin
        cmd.blend  = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/servo_command_gate.sv
// Sequencing: an accepted tick, poll or mark request is decoded and its result loaded into the
// output register; so is a command whose link is down or joint never marked, which otherwise adds
// the elapsed and gate steps (in warm-up), then the product step (past the ramp), and when ramped
// the 16-step serial divider of the blend. One request is in work at a time; the next is taken
// once the result is loaded; a result left waiting in the output register holds the last step.
// Synchronous active-high reset restores register defaults and the per-joint flags and counters.
`default_nettype none

module servo_command_gate #(
  parameter int unsigned NUM_JOINTS = scg_pkg::NUM_JOINTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [scg_pkg::OP_W-1:0]          opcode,
  input  wire logic [scg_pkg::JOINT_W-1:0]       joint_index,
  input  wire logic                              read_ok,
  input  wire logic signed [scg_pkg::POS_W-1:0]  position_in,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   accepted,
  output logic signed [scg_pkg::POS_W-1:0]       position_out,
  output logic      [scg_pkg::JOINT_W-1:0]       polled_joint,
  output logic                                   link_up,
  output logic                                   reenable_request,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [scg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [scg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import scg_pkg::*;

  scg_cmd_t    cmd;
  scg_status_t status;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  // Sequencing of each request.
  scg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // State, arithmetic and output register.
  scg_datapath #(
    .NUM_JOINTS (NUM_JOINTS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .opcode           (opcode),
    .joint_index      (joint_index),
    .read_ok          (read_ok),
    .position_in      (position_in),
    .cfg_write        (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .accepted         (accepted),
    .position_out     (position_out),
    .polled_joint     (polled_joint),
    .link_up          (link_up),
    .reenable_request (reenable_request)
  );

  // A request in work blocks the next one.
  a_one_in_work : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in work");

  // A reconnect is only reported together with a raised link flag.
  a_reenable_link : assert property (@(posedge clk) disable iff (rst)
    out_valid && reenable_request |-> link_up)
    else $error("reenable_request without link_up");

  // Command results never carry poll fields.
  a_cmd_no_poll : assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> !link_up && !reenable_request && (polled_joint == '0))
    else $error("accepted command carries poll fields");

endmodule

`default_nettype wire
